/* rtl/pcfe_pkg.sv */
// Shared types and constants of the point charge field engine.
package pcfe_pkg;

   // Operation codes carried by req_opcode.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Fixed-point layout.
   localparam int FIELD_W      = 40;  // Q8.32 field components
   localparam int DIR_W        = 16;  // Q1.15 direction components
   localparam int DIR_FRAC     = 15;
   localparam int NEAR_W       = 16;
   localparam int TERM_FRAC    = 44;  // term numerator shift
   localparam int ROOT_PRESH   = 24;  // r2 is scaled by 2^24 before the root
   localparam int ROOT_IN_W    = 64;
   localparam int ROOT_W       = 32;
   localparam int QUO_W        = 33;  // quotient bits produced by the divider
   localparam int STEP_W       = 6;
   localparam int NORM_LIMIT_B = 31;  // magnitudes are scaled below 2^31

   localparam logic [NEAR_W-1:0]  NEAR_RESET = 16'd100;
   localparam logic [DIR_W-2:0]   DIR_MAX    = 15'h7FFF;
   localparam logic [STEP_W-1:0]  ROOT_LAST  = 6'd31;
   localparam logic [STEP_W-1:0]  DIV_LAST   = 6'd32;

   typedef enum logic [21:0] {
      ST_IDLE  = 22'h000001,
      ST_RD    = 22'h000002,
      ST_DIFF  = 22'h000004,
      ST_R2X   = 22'h000008,
      ST_R2Y   = 22'h000010,
      ST_CHK   = 22'h000020,
      ST_SQRT  = 22'h000040,
      ST_MULD  = 22'h000080,
      ST_DIVX  = 22'h000100,
      ST_ACCX  = 22'h000200,
      ST_DIVY  = 22'h000400,
      ST_ACCY  = 22'h000800,
      ST_SAT   = 22'h001000,
      ST_NORM  = 22'h002000,
      ST_SQA   = 22'h004000,
      ST_SQB   = 22'h008000,
      ST_MSQRT = 22'h010000,
      ST_LDC   = 22'h020000,
      ST_DCOS  = 22'h040000,
      ST_LDS   = 22'h080000,
      ST_DSIN  = 22'h100000,
      ST_FIN   = 22'h200000
   } state_type;

endpackage

/* rtl/point_charge_field_engine_unit.sv */
// Top level of the point charge field engine: charge table, sequencer and shared units.
//
//  Channel   | Ports                                          | Handshake
//  ----------+------------------------------------------------+---------------------------
//  request   | req_opcode, req_pos_x, req_pos_y,              | taken when start & !busy
//            | req_is_positive                                |
//  response  | rsp_field_x/y, rsp_dir_cos/sin, rsp_zero_field,| rsp_valid high one cycle,
//            | rsp_near_*, rsp_table_full                     | receiver cannot stall
//  config    | csr_wr_en, csr_wr_data (near_limit_sq)         | written when csr_wr_en
//
// A clear, add or no-op transaction is answered in the cycle after it is taken and
// busy never rises, so a new transaction can follow at once.
// A query walks the stored charges one at a time through one shared multiplier, one
// bit-serial square root unit (32 steps) and one restoring divider (33 steps).
// Each charge is read, squared, checked, rooted, multiplied, then divided and accumulated
// per axis, and stops after the check when it sits on the query point; the final direction
// pass halves the magnitudes below 2^31 (at most nine shifts) and is skipped for a zero field.
// Reset is synchronous and active high; it empties the table and sets the near limit
// to 100. The charge table itself has no reset, since only written entries are read.
module point_charge_field_engine_unit #(
   parameter int MAX_CHARGES = 64,
   parameter int COORD_BITS  = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  logic [COORD_BITS-1:0]                 req_pos_x,
   input  logic [COORD_BITS-1:0]                 req_pos_y,
   input  logic                                  req_is_positive,
   output logic                                  rsp_valid,
   output logic signed [pcfe_pkg::FIELD_W-1:0]   rsp_field_x,
   output logic signed [pcfe_pkg::FIELD_W-1:0]   rsp_field_y,
   output logic signed [pcfe_pkg::DIR_W-1:0]     rsp_dir_cos,
   output logic signed [pcfe_pkg::DIR_W-1:0]     rsp_dir_sin,
   output logic                                  rsp_zero_field,
   output logic                                  rsp_near_neg_hit,
   output logic [COORD_BITS-1:0]                 rsp_near_neg_x,
   output logic [COORD_BITS-1:0]                 rsp_near_neg_y,
   output logic                                  rsp_near_pos_hit,
   output logic [COORD_BITS-1:0]                 rsp_near_pos_x,
   output logic [COORD_BITS-1:0]                 rsp_near_pos_y,
   output logic                                  rsp_table_full,
   input  logic                                  csr_wr_en,
   input  logic [pcfe_pkg::NEAR_W-1:0]           csr_wr_data
);

   // Derived widths. The divider is sized for the per-charge denominator r2 * root,
   // which is wider than the 32-bit direction-pass magnitude when COORD_BITS >= 7.
   localparam int CB      = COORD_BITS;
   localparam int R2W     = 2 * CB + 1;
   localparam int MW      = (R2W > 32) ? R2W : 32;
   localparam int DVW     = 3 * CB + 14;
   localparam int QW      = pcfe_pkg::QUO_W;
   localparam int NMW     = DVW + QW;
   localparam int ACW_RAW = 35 + $clog2(MAX_CHARGES);
   localparam int ACW     = (ACW_RAW > 41) ? ACW_RAW : 41;
   localparam int FW      = pcfe_pkg::FIELD_W;
   localparam int CNTW    = $clog2(MAX_CHARGES + 1);
   localparam int AW      = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
   localparam int EW      = 2 * CB + 1;
   localparam int RIW     = pcfe_pkg::ROOT_IN_W;
   localparam int RW      = pcfe_pkg::ROOT_W;

   // Charge table: one entry holds {sign, y, x}.
   logic [EW-1:0] table_mem [MAX_CHARGES];
   logic [EW-1:0] rdata_ff;
   logic          mem_we;
   logic [EW-1:0] mem_wdata;

   pcfe_pkg::state_type state_ff, state_in;

   logic [CNTW-1:0]           cnt_ff, cnt_in;
   logic [CNTW-1:0]           idx_ff, idx_in;
   logic [pcfe_pkg::NEAR_W-1:0] near_lim_ff;
   logic [CB-1:0]             px_ff, px_in, py_ff, py_in;

   logic [CB-1:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic                      dxn_ff, dxn_in, dyn_ff, dyn_in;
   logic [R2W-1:0]            r2_ff, r2_in;
   logic [DVW-1:0]            den_ff, den_in;
   logic signed [ACW-1:0]     accx_ff, accx_in, accy_ff, accy_in;

   logic                      nh_ff, nh_in, ph_ff, ph_in;
   logic [CB-1:0]             nx_ff, nx_in, ny_ff, ny_in, qx_ff, qx_in, qy_ff, qy_in;

   logic signed [FW-1:0]      fx_ff, fx_in, fy_ff, fy_in;
   logic [FW-1:0]             a_ff, a_in, b_ff, b_in;
   logic [RIW-1:0]            sum_ff, sum_in;
   logic                      zf_ff, zf_in;
   logic signed [pcfe_pkg::DIR_W-1:0] dc_ff, dc_in, ds_ff, ds_in;

   // Shared square root unit.
   logic [RIW-1:0]            sq_v_ff, sq_v_in;
   logic [RW+1:0]             sq_rem_ff, sq_rem_in;
   logic [RW-1:0]             sq_root_ff, sq_root_in;
   logic [RW+3:0]             sq_rem2, sq_trial;
   logic                      sq_ge;

   // Shared restoring divider; dv_q holds the low numerator bits, then the quotient.
   logic [DVW-1:0]            dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic [QW-1:0]             dv_q_ff, dv_q_in;
   logic [DVW:0]              dv_t;
   logic                      dv_ge;

   logic [pcfe_pkg::STEP_W-1:0] step_ff, step_in;

   // Shared multiplier.
   logic [MW-1:0]             mul_a, mul_b;
   logic [2*MW-1:0]           mul_p;

   // Result registers.
   logic                      rv_ff, rv_in;
   logic signed [FW-1:0]      o_fx_ff, o_fx_in, o_fy_ff, o_fy_in;
   logic signed [pcfe_pkg::DIR_W-1:0] o_dc_ff, o_dc_in, o_ds_ff, o_ds_in;
   logic                      o_zf_ff, o_zf_in, o_nh_ff, o_nh_in, o_ph_ff, o_ph_in;
   logic                      o_full_ff, o_full_in;
   logic [CB-1:0]             o_nx_ff, o_nx_in, o_ny_ff, o_ny_in;
   logic [CB-1:0]             o_qx_ff, o_qx_in, o_qy_ff, o_qy_in;

   logic                      accept;

   function automatic logic signed [FW-1:0] sat_field(input logic signed [ACW-1:0] v);
      logic fits;
      fits = (&v[ACW-1:FW-1]) || !(|v[ACW-1:FW-1]);
      if (fits) begin
         return v[FW-1:0];
      end
      return {v[ACW-1], {(FW-1){~v[ACW-1]}}};
   endfunction

   function automatic logic signed [pcfe_pkg::DIR_W-1:0] dir_val(input logic [QW-1:0] q,
                                                                   input logic neg);
      logic [pcfe_pkg::DIR_W-2:0] qc;
      logic signed [pcfe_pkg::DIR_W-1:0] pv;
      qc = (q > QW'(pcfe_pkg::DIR_MAX)) ? pcfe_pkg::DIR_MAX : q[pcfe_pkg::DIR_W-2:0];
      pv = {1'b0, qc};
      return neg ? -pv : pv;
   endfunction

   assign accept = start && (state_ff == pcfe_pkg::ST_IDLE);
   assign busy   = (state_ff != pcfe_pkg::ST_IDLE);

   assign mul_p = mul_a * mul_b;

   // One square root step: bring in two radicand bits and try 4*root + 1.
   assign sq_rem2  = {sq_rem_ff, sq_v_ff[RIW-1 -: 2]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge    = (sq_rem2 >= sq_trial);

   // One divider step: bring in one numerator bit and try the denominator.
   assign dv_t  = {dv_rem_ff, dv_q_ff[QW-1]};
   assign dv_ge = (dv_t >= {1'b0, dv_den_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         pcfe_pkg::ST_R2X: begin
            mul_a = MW'(ax_ff);
            mul_b = MW'(ax_ff);
         end
         pcfe_pkg::ST_R2Y: begin
            mul_a = MW'(ay_ff);
            mul_b = MW'(ay_ff);
         end
         pcfe_pkg::ST_MULD: begin
            mul_a = MW'(r2_ff);
            mul_b = MW'(sq_root_ff);
         end
         pcfe_pkg::ST_SQA: begin
            mul_a = MW'(a_ff[pcfe_pkg::NORM_LIMIT_B-1:0]);
            mul_b = MW'(a_ff[pcfe_pkg::NORM_LIMIT_B-1:0]);
         end
         pcfe_pkg::ST_SQB: begin
            mul_a = MW'(b_ff[pcfe_pkg::NORM_LIMIT_B-1:0]);
            mul_b = MW'(b_ff[pcfe_pkg::NORM_LIMIT_B-1:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      logic [CB:0]             dx, dy;
      logic [NMW-1:0]          num;
      logic signed [ACW-1:0]   term;
      logic                    advance, near, tneg;
      logic [DVW-1:0]          den_now;

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      dxn_in     = dxn_ff;
      dyn_in     = dyn_ff;
      r2_in      = r2_ff;
      den_in     = den_ff;
      accx_in    = accx_ff;
      accy_in    = accy_ff;
      nh_in      = nh_ff;
      ph_in      = ph_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      sum_in     = sum_ff;
      zf_in      = zf_ff;
      dc_in      = dc_ff;
      ds_in      = ds_ff;
      sq_v_in    = sq_v_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      dv_rem_in  = dv_rem_ff;
      dv_den_in  = dv_den_ff;
      dv_q_in    = dv_q_ff;
      step_in    = step_ff;
      rv_in      = 1'b0;
      o_fx_in    = o_fx_ff;
      o_fy_in    = o_fy_ff;
      o_dc_in    = o_dc_ff;
      o_ds_in    = o_ds_ff;
      o_zf_in    = o_zf_ff;
      o_nh_in    = o_nh_ff;
      o_ph_in    = o_ph_ff;
      o_full_in  = o_full_ff;
      o_nx_in    = o_nx_ff;
      o_ny_in    = o_ny_ff;
      o_qx_in    = o_qx_ff;
      o_qy_in    = o_qy_ff;
      mem_we     = 1'b0;
      mem_wdata  = {req_is_positive, req_pos_y, req_pos_x};

      dx      = {1'b0, px_ff} - {1'b0, rdata_ff[CB-1:0]};
      dy      = {1'b0, py_ff} - {1'b0, rdata_ff[2*CB-1:CB]};
      num     = '0;
      term    = ACW'(dv_q_ff);
      advance = 1'b0;
      near    = (r2_ff < R2W'(near_lim_ff));
      tneg    = 1'b0;
      den_now = mul_p[DVW-1:0];

      unique case (state_ff)
         pcfe_pkg::ST_IDLE: begin
            if (accept) begin
               px_in     = req_pos_x;
               py_in     = req_pos_y;
               o_fx_in   = '0;
               o_fy_in   = '0;
               o_dc_in   = '0;
               o_ds_in   = '0;
               o_zf_in   = 1'b0;
               o_nh_in   = 1'b0;
               o_ph_in   = 1'b0;
               o_full_in = 1'b0;
               o_nx_in   = '0;
               o_ny_in   = '0;
               o_qx_in   = '0;
               o_qy_in   = '0;
               unique case (req_opcode)
                  pcfe_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                     rv_in  = 1'b1;
                  end
                  pcfe_pkg::OP_ADD: begin
                     if (cnt_ff < CNTW'(MAX_CHARGES)) begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end else begin
                        o_full_in = 1'b1;
                     end
                     rv_in = 1'b1;
                  end
                  pcfe_pkg::OP_QUERY: begin
                     idx_in  = '0;
                     accx_in = '0;
                     accy_in = '0;
                     nh_in   = 1'b0;
                     ph_in   = 1'b0;
                     nx_in   = '0;
                     ny_in   = '0;
                     qx_in   = '0;
                     qy_in   = '0;
                     state_in = (cnt_ff == '0) ? pcfe_pkg::ST_SAT : pcfe_pkg::ST_RD;
                  end
                  default: begin
                     rv_in = 1'b1;
                  end
               endcase
            end
         end
         pcfe_pkg::ST_RD: begin
            state_in = pcfe_pkg::ST_DIFF;
         end
         pcfe_pkg::ST_DIFF: begin
            dxn_in   = dx[CB];
            dyn_in   = dy[CB];
            ax_in    = dx[CB] ? CB'(-dx) : dx[CB-1:0];
            ay_in    = dy[CB] ? CB'(-dy) : dy[CB-1:0];
            state_in = pcfe_pkg::ST_R2X;
         end
         pcfe_pkg::ST_R2X: begin
            r2_in    = mul_p[R2W-1:0];
            state_in = pcfe_pkg::ST_R2Y;
         end
         pcfe_pkg::ST_R2Y: begin
            r2_in    = r2_ff + mul_p[R2W-1:0];
            state_in = pcfe_pkg::ST_CHK;
         end
         pcfe_pkg::ST_CHK: begin
            if (near) begin
               if (rdata_ff[EW-1] && !ph_ff) begin
                  ph_in = 1'b1;
                  qx_in = rdata_ff[CB-1:0];
                  qy_in = rdata_ff[2*CB-1:CB];
               end
               if (!rdata_ff[EW-1] && !nh_ff) begin
                  nh_in = 1'b1;
                  nx_in = rdata_ff[CB-1:0];
                  ny_in = rdata_ff[2*CB-1:CB];
               end
            end
            if (r2_ff == '0) begin
               // A charge sitting on the query point adds no field term.
               advance = 1'b1;
            end else begin
               sq_v_in    = RIW'(r2_ff) << pcfe_pkg::ROOT_PRESH;
               sq_rem_in  = '0;
               sq_root_in = '0;
               step_in    = '0;
               state_in   = pcfe_pkg::ST_SQRT;
            end
         end
         pcfe_pkg::ST_SQRT, pcfe_pkg::ST_MSQRT: begin
            sq_rem_in  = sq_ge ? (RW+2)'(sq_rem2 - sq_trial) : sq_rem2[RW+1:0];
            sq_root_in = {sq_root_ff[RW-2:0], sq_ge};
            sq_v_in    = {sq_v_ff[RIW-3:0], 2'b00};
            step_in    = step_ff + 1'b1;
            if (step_ff == pcfe_pkg::ROOT_LAST) begin
               state_in = (state_ff == pcfe_pkg::ST_SQRT) ? pcfe_pkg::ST_MULD
                                                          : pcfe_pkg::ST_LDC;
            end
         end
         pcfe_pkg::ST_MULD: begin
            den_in    = den_now;
            num       = (NMW'(ax_ff) << pcfe_pkg::TERM_FRAC) + NMW'(den_now >> 1);
            dv_den_in = den_now;
            dv_rem_in = num[NMW-1:QW];
            dv_q_in   = num[QW-1:0];
            step_in   = '0;
            state_in  = pcfe_pkg::ST_DIVX;
         end
         pcfe_pkg::ST_DIVX, pcfe_pkg::ST_DIVY, pcfe_pkg::ST_DCOS, pcfe_pkg::ST_DSIN: begin
            dv_rem_in = dv_ge ? DVW'(dv_t - {1'b0, dv_den_ff}) : dv_t[DVW-1:0];
            dv_q_in   = {dv_q_ff[QW-2:0], dv_ge};
            step_in   = step_ff + 1'b1;
            if (step_ff == pcfe_pkg::DIV_LAST) begin
               unique case (state_ff)
                  pcfe_pkg::ST_DIVX: state_in = pcfe_pkg::ST_ACCX;
                  pcfe_pkg::ST_DIVY: state_in = pcfe_pkg::ST_ACCY;
                  pcfe_pkg::ST_DCOS: state_in = pcfe_pkg::ST_LDS;
                  default:           state_in = pcfe_pkg::ST_FIN;
               endcase
            end
         end
         pcfe_pkg::ST_ACCX: begin
            tneg      = dxn_ff ^ !rdata_ff[EW-1];
            accx_in   = tneg ? (accx_ff - term) : (accx_ff + term);
            num       = (NMW'(ay_ff) << pcfe_pkg::TERM_FRAC) + NMW'(den_ff >> 1);
            dv_rem_in = num[NMW-1:QW];
            dv_q_in   = num[QW-1:0];
            step_in   = '0;
            state_in  = pcfe_pkg::ST_DIVY;
         end
         pcfe_pkg::ST_ACCY: begin
            tneg    = dyn_ff ^ !rdata_ff[EW-1];
            accy_in = tneg ? (accy_ff - term) : (accy_ff + term);
            advance = 1'b1;
         end
         pcfe_pkg::ST_SAT: begin
            fx_in = sat_field(accx_ff);
            fy_in = sat_field(accy_ff);
            a_in  = fx_in[FW-1] ? FW'(-fx_in) : fx_in;
            b_in  = fy_in[FW-1] ? FW'(-fy_in) : fy_in;
            dc_in = '0;
            ds_in = '0;
            if ((fx_in == '0) && (fy_in == '0)) begin
               zf_in    = 1'b1;
               state_in = pcfe_pkg::ST_FIN;
            end else begin
               zf_in    = 1'b0;
               state_in = pcfe_pkg::ST_NORM;
            end
         end
         pcfe_pkg::ST_NORM: begin
            if (|((a_ff | b_ff) >> pcfe_pkg::NORM_LIMIT_B)) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
            end else begin
               state_in = pcfe_pkg::ST_SQA;
            end
         end
         pcfe_pkg::ST_SQA: begin
            sum_in   = RIW'(mul_p);
            state_in = pcfe_pkg::ST_SQB;
         end
         pcfe_pkg::ST_SQB: begin
            sq_v_in    = sum_ff + RIW'(mul_p);
            sq_rem_in  = '0;
            sq_root_in = '0;
            step_in    = '0;
            state_in   = pcfe_pkg::ST_MSQRT;
         end
         pcfe_pkg::ST_LDC: begin
            num       = (NMW'(a_ff) << pcfe_pkg::DIR_FRAC) + NMW'(sq_root_ff >> 1);
            dv_den_in = DVW'(sq_root_ff);
            dv_rem_in = num[NMW-1:QW];
            dv_q_in   = num[QW-1:0];
            step_in   = '0;
            state_in  = pcfe_pkg::ST_DCOS;
         end
         pcfe_pkg::ST_LDS: begin
            dc_in     = dir_val(dv_q_ff, fx_ff[FW-1]);
            num       = (NMW'(b_ff) << pcfe_pkg::DIR_FRAC) + NMW'(dv_den_ff >> 1);
            dv_rem_in = num[NMW-1:QW];
            dv_q_in   = num[QW-1:0];
            step_in   = '0;
            state_in  = pcfe_pkg::ST_DSIN;
         end
         pcfe_pkg::ST_FIN: begin
            rv_in     = 1'b1;
            o_fx_in   = fx_ff;
            o_fy_in   = fy_ff;
            o_dc_in   = dc_ff;
            o_ds_in   = zf_ff ? '0 : dir_val(dv_q_ff, fy_ff[FW-1]);
            o_zf_in   = zf_ff;
            o_nh_in   = nh_ff;
            o_nx_in   = nx_ff;
            o_ny_in   = ny_ff;
            o_ph_in   = ph_ff;
            o_qx_in   = qx_ff;
            o_qy_in   = qy_ff;
            o_full_in = 1'b0;
            state_in  = pcfe_pkg::ST_IDLE;
         end
         default: begin
            state_in = pcfe_pkg::ST_IDLE;
         end
      endcase

      if (advance) begin
         if (CNTW'(idx_ff + 1'b1) < cnt_ff) begin
            idx_in   = idx_ff + 1'b1;
            state_in = pcfe_pkg::ST_RD;
         end else begin
            state_in = pcfe_pkg::ST_SAT;
         end
      end
   end

   // Charge table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[cnt_ff[AW-1:0]] <= mem_wdata;
      end
      rdata_ff <= table_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pcfe_pkg::ST_IDLE;
         cnt_ff      <= '0;
         near_lim_ff <= pcfe_pkg::NEAR_RESET;
         rv_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) begin
            near_lim_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      dxn_ff     <= dxn_in;
      dyn_ff     <= dyn_in;
      r2_ff      <= r2_in;
      den_ff     <= den_in;
      accx_ff    <= accx_in;
      accy_ff    <= accy_in;
      nh_ff      <= nh_in;
      ph_ff      <= ph_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      sum_ff     <= sum_in;
      zf_ff      <= zf_in;
      dc_ff      <= dc_in;
      ds_ff      <= ds_in;
      sq_v_ff    <= sq_v_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      dv_rem_ff  <= dv_rem_in;
      dv_den_ff  <= dv_den_in;
      dv_q_ff    <= dv_q_in;
      step_ff    <= step_in;
      o_fx_ff    <= o_fx_in;
      o_fy_ff    <= o_fy_in;
      o_dc_ff    <= o_dc_in;
      o_ds_ff    <= o_ds_in;
      o_zf_ff    <= o_zf_in;
      o_nh_ff    <= o_nh_in;
      o_ph_ff    <= o_ph_in;
      o_full_ff  <= o_full_in;
      o_nx_ff    <= o_nx_in;
      o_ny_ff    <= o_ny_in;
      o_qx_ff    <= o_qx_in;
      o_qy_ff    <= o_qy_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_field_x      = o_fx_ff;
   assign rsp_field_y      = o_fy_ff;
   assign rsp_dir_cos      = o_dc_ff;
   assign rsp_dir_sin      = o_ds_ff;
   assign rsp_zero_field   = o_zf_ff;
   assign rsp_near_neg_hit = o_nh_ff;
   assign rsp_near_neg_x   = o_nx_ff;
   assign rsp_near_neg_y   = o_ny_ff;
   assign rsp_near_pos_hit = o_ph_ff;
   assign rsp_near_pos_x   = o_qx_ff;
   assign rsp_near_pos_y   = o_qy_ff;
   assign rsp_table_full   = o_full_ff;

endmodule

/* rtl/pcfe_checker.sv */
// Port-level checker for the point charge field engine and its bind statement.
module pcfe_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [1:0]                          req_opcode,
   input logic                                rsp_valid,
   input logic signed [pcfe_pkg::FIELD_W-1:0] rsp_field_x,
   input logic signed [pcfe_pkg::FIELD_W-1:0] rsp_field_y,
   input logic signed [pcfe_pkg::DIR_W-1:0]   rsp_dir_cos,
   input logic signed [pcfe_pkg::DIR_W-1:0]   rsp_dir_sin,
   input logic                                rsp_zero_field,
   input logic                                rsp_near_pos_hit,
   input logic                                rsp_near_neg_hit,
   input logic [COORD_BITS-1:0]               rsp_near_pos_x,
   input logic                                rsp_table_full
);

   // A transaction that is not a query is answered in the next cycle.
   a_short_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != pcfe_pkg::OP_QUERY) |=> rsp_valid)
      else $error("clear/add transaction not answered in the next cycle");

   // A query makes the block busy and gives no immediate result.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == pcfe_pkg::OP_QUERY) |=> (busy && !rsp_valid))
      else $error("query did not occupy the block");

   // The end of a query always comes with its result.
   a_query_done: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("query finished without a result");

   // A zero field carries no direction.
   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_field) |-> (rsp_dir_cos == '0 && rsp_dir_sin == '0))
      else $error("direction reported for a zero field");

   // A dropped add reports nothing of a query.
   a_full_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_field_x == '0 && rsp_field_y == '0
         && !rsp_near_pos_hit && !rsp_near_neg_hit && rsp_near_pos_x == '0))
      else $error("table full flag with query data");

endmodule

bind point_charge_field_engine_unit pcfe_checker #(.COORD_BITS(COORD_BITS)) u_pcfe_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_opcode       (req_opcode),
   .rsp_valid        (rsp_valid),
   .rsp_field_x      (rsp_field_x),
   .rsp_field_y      (rsp_field_y),
   .rsp_dir_cos      (rsp_dir_cos),
   .rsp_dir_sin      (rsp_dir_sin),
   .rsp_zero_field   (rsp_zero_field),
   .rsp_near_pos_hit (rsp_near_pos_hit),
   .rsp_near_neg_hit (rsp_near_neg_hit),
   .rsp_near_pos_x   (rsp_near_pos_x),
   .rsp_table_full   (rsp_table_full)
);

/* tb/sv/tb.sv */
// Self-checking testbench of the point charge field engine top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Opcode 3 has no name in the package; the block answers it with all zeros.
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int TABLE_DEPTH = 64;

   // One response transaction, field by field.
   typedef struct packed {
      logic signed [pcfe_pkg::FIELD_W-1:0] field_x;
      logic signed [pcfe_pkg::FIELD_W-1:0] field_y;
      logic signed [pcfe_pkg::DIR_W-1:0]   dir_cos;
      logic signed [pcfe_pkg::DIR_W-1:0]   dir_sin;
      logic                      zero_field;
      logic                      neg_hit;
      logic [11:0]               neg_x;
      logic [11:0]               neg_y;
      logic                      pos_hit;
      logic [11:0]               pos_x;
      logic [11:0]               pos_y;
      logic                      table_full;
   } field_result_type;

   // Keeps its own charge table, predicts each response and checks it in order.
   class field_scoreboard;
      logic [11:0] xpos [TABLE_DEPTH];
      logic [11:0] ypos [TABLE_DEPTH];
      logic        sign [TABLE_DEPTH];
      int unsigned count;
      logic [15:0] near_limit;
      field_result_type pending_results[$];
      bit failed;

      function new();
         count = 0;
         near_limit = pcfe_pkg::NEAR_RESET;
         failed = 0;
      endfunction

      static function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      static function logic signed [15:0] direction(longint unsigned a, longint unsigned mag,
                                                    bit neg);
         longint unsigned q;
         q = ((a << 15) + (mag >> 1)) / mag;
         if (q > 32767) q = 32767;
         return neg ? -$signed(16'(q)) : $signed(16'(q));
      endfunction

      function void note_request(logic [1:0] op, logic [11:0] x, logic [11:0] y, logic pos);
         field_result_type r;
         longint ex, ey, dx, dy;
         longint unsigned ax, ay, r2, root, den, tx, ty, a, b, mag;
         bit chg_pos;
         r = '0;
         ex = 0;
         ey = 0;
         if (op == pcfe_pkg::OP_CLEAR) begin
            count = 0;
         end else if (op == pcfe_pkg::OP_ADD) begin
            if (count < TABLE_DEPTH) begin
               xpos[count] = x;
               ypos[count] = y;
               sign[count] = pos;
               count++;
            end else begin
               r.table_full = 1'b1;
            end
         end else if (op == pcfe_pkg::OP_QUERY) begin
            for (int i = 0; i < count; i++) begin
               dx = longint'(x) - longint'(xpos[i]);
               dy = longint'(y) - longint'(ypos[i]);
               ax = dx < 0 ? -dx : dx;
               ay = dy < 0 ? -dy : dy;
               r2 = ax * ax + ay * ay;
               chg_pos = sign[i];
               if (r2 < near_limit) begin
                  if (chg_pos && !r.pos_hit) begin
                     r.pos_hit = 1'b1;
                     r.pos_x = xpos[i];
                     r.pos_y = ypos[i];
                  end
                  if (!chg_pos && !r.neg_hit) begin
                     r.neg_hit = 1'b1;
                     r.neg_x = xpos[i];
                     r.neg_y = ypos[i];
                  end
               end
               // A charge sitting on the query point contributes no field.
               if (r2 != 0) begin
                  root = int_sqrt(r2 << 24);
                  den = r2 * root;
                  tx = ((ax << 44) + (den >> 1)) / den;
                  ty = ((ay << 44) + (den >> 1)) / den;
                  ex += ((dx < 0) != !chg_pos) ? -longint'(tx) : longint'(tx);
                  ey += ((dy < 0) != !chg_pos) ? -longint'(ty) : longint'(ty);
               end
            end
            if (ex > 64'sd549755813887) ex = 64'sd549755813887;
            if (ex < -64'sd549755813888) ex = -64'sd549755813888;
            if (ey > 64'sd549755813887) ey = 64'sd549755813887;
            if (ey < -64'sd549755813888) ey = -64'sd549755813888;
            r.field_x = ex[pcfe_pkg::FIELD_W-1:0];
            r.field_y = ey[pcfe_pkg::FIELD_W-1:0];
            if (ex == 0 && ey == 0) begin
               r.zero_field = 1'b1;
            end else begin
               a = ex < 0 ? -ex : ex;
               b = ey < 0 ? -ey : ey;
               while ((a > b ? a : b) >= (64'd1 << 31)) begin
                  a >>= 1;
                  b >>= 1;
               end
               mag = int_sqrt(a * a + b * b);
               r.dir_cos = direction(a, mag, ex < 0);
               r.dir_sin = direction(b, mag, ey < 0);
            end
         end
         pending_results.push_back(r);
      endfunction

      function void check_response(field_result_type act);
         field_result_type exp_r;
         if (pending_results.size() == 0) begin
            $display("%t unexpected response %p", $realtime, act);
            failed = 1;
            return;
         end
         exp_r = pending_results.pop_front();
         if (act !== exp_r) begin
            $display("%t mismatch expected %p actual %p", $realtime, exp_r, act);
            failed = 1;
         end
      endfunction
   endclass

   logic clock, reset, start, busy;
   logic [1:0] req_opcode;
   logic [11:0] req_pos_x, req_pos_y;
   logic req_is_positive;
   logic rsp_valid;
   logic signed [pcfe_pkg::FIELD_W-1:0] rsp_field_x, rsp_field_y;
   logic signed [pcfe_pkg::DIR_W-1:0]   rsp_dir_cos, rsp_dir_sin;
   logic rsp_zero_field, rsp_near_neg_hit, rsp_near_pos_hit, rsp_table_full;
   logic [11:0] rsp_near_neg_x, rsp_near_neg_y, rsp_near_pos_x, rsp_near_pos_y;
   field_result_type rsp;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   field_scoreboard sb;
   int sender_idle_pct;
   int items_sent;

   point_charge_field_engine_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_is_positive(req_is_positive),
      .rsp_valid(rsp_valid),
      .rsp_field_x(rsp_field_x), .rsp_field_y(rsp_field_y),
      .rsp_dir_cos(rsp_dir_cos), .rsp_dir_sin(rsp_dir_sin),
      .rsp_zero_field(rsp_zero_field),
      .rsp_near_neg_hit(rsp_near_neg_hit), .rsp_near_neg_x(rsp_near_neg_x),
      .rsp_near_neg_y(rsp_near_neg_y),
      .rsp_near_pos_hit(rsp_near_pos_hit), .rsp_near_pos_x(rsp_near_pos_x),
      .rsp_near_pos_y(rsp_near_pos_y),
      .rsp_table_full(rsp_table_full),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   assign rsp = {rsp_field_x, rsp_field_y, rsp_dir_cos, rsp_dir_sin, rsp_zero_field,
                 rsp_near_neg_hit, rsp_near_neg_x, rsp_near_neg_y,
                 rsp_near_pos_hit, rsp_near_pos_x, rsp_near_pos_y, rsp_table_full};

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // A generous wall: even if every transaction were a query on a full table,
   // the run would stay well below this.
   initial begin
      #1_000_000_000;
      $display("** point_charge_field_engine_unit: FAILED **");
      $finish;
   end

   // Responses cannot be held off, so every strobe is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp);
   end

   // Presents one request transaction and returns at the edge where it is taken.
   // It must be called right after a rising edge; the caller decides about the gap.
   task automatic send_request(logic [1:0] op, int x, int y, logic pos);
      start <= 1;
      req_opcode <= op;
      req_pos_x <= x[11:0];
      req_pos_y <= y[11:0];
      req_is_positive <= pos;
      do @(posedge clock); while (busy);
      sb.note_request(op, x[11:0], y[11:0], pos);
      items_sent++;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drains outstanding responses so the near limit can be changed safely.
   task automatic drain;
      start <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_near_limit(logic [15:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.near_limit = v;
   endtask

   function automatic int clamp_coord(int v);
      return v < 0 ? 0 : (v > 4095 ? 4095 : v);
   endfunction

   // One well-formed burst: an optional clear, a few adds clustered or spread out,
   // then queries aimed at random points, next to stored charges or right on them.
   task automatic charge_burst;
      int n_add, n_query, bx, by, k, qx, qy, pick;
      bx = $urandom_range(0, 4095);
      by = $urandom_range(0, 4095);
      if ($urandom_range(0, 9) != 0)
         send_request(pcfe_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom));
      // Now and then fill the table past its end so drops are seen.
      n_add = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 6);
      for (int i = 0; i < n_add; i++) begin
         if ($urandom_range(0, 1))
            send_request(pcfe_pkg::OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         1'($urandom));
         else
            send_request(pcfe_pkg::OP_ADD, clamp_coord(bx + $urandom_range(0, 40) - 20),
                         clamp_coord(by + $urandom_range(0, 40) - 20), 1'($urandom));
      end
      n_query = $urandom_range(1, 4);
      for (int i = 0; i < n_query; i++) begin
         pick = $urandom_range(0, 5);
         if (sb.count == 0 || pick < 2) begin
            qx = $urandom_range(0, 4095);
            qy = $urandom_range(0, 4095);
         end else begin
            k = $urandom_range(0, sb.count - 1);
            qx = int'(sb.xpos[k]);
            qy = int'(sb.ypos[k]);
            if (pick != 5) begin
               qx = clamp_coord(qx + $urandom_range(0, 16) - 8);
               qy = clamp_coord(qy + $urandom_range(0, 16) - 8);
            end
         end
         send_request(pcfe_pkg::OP_QUERY, qx, qy, 1'($urandom));
         // Occasional noise: a no-op or a stray add in the middle of the queries.
         if ($urandom_range(0, 9) == 0) send_request(OP_NOP, $urandom, $urandom, 1'($urandom));
         if ($urandom_range(0, 19) == 0)
            send_request(pcfe_pkg::OP_ADD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         1'($urandom));
      end
   endtask

   initial begin
      logic [15:0] limits [6];
      sb = new();
      items_sent = 0;
      sender_idle_pct = 0;
      reset = 1;
      start = 0;
      req_opcode = pcfe_pkg::OP_CLEAR;
      req_pos_x = '0;
      req_pos_y = '0;
      req_is_positive = 0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with the reset near limit of 100.
      send_request(pcfe_pkg::OP_QUERY, 0, 0, 0);        // empty table: zero field
      send_request(pcfe_pkg::OP_ADD, 0, 0, 0);          // corner charges, both signs
      send_request(pcfe_pkg::OP_ADD, 4095, 4095, 1);
      send_request(pcfe_pkg::OP_QUERY, 0, 0, 1);        // on top of the negative charge
      send_request(pcfe_pkg::OP_QUERY, 4095, 4095, 0);  // on top of the positive charge
      send_request(pcfe_pkg::OP_QUERY, 2048, 2048, 0);
      send_request(pcfe_pkg::OP_QUERY, 5, 5, 0);        // near but not on a charge
      send_request(OP_NOP, 4095, 4095, 1);
      send_request(pcfe_pkg::OP_CLEAR, 0, 0, 0);
      send_request(pcfe_pkg::OP_QUERY, 4095, 0, 0);     // table cleared again
      send_request(pcfe_pkg::OP_ADD, 100, 100, 1);      // equal charges either side cancel
      send_request(pcfe_pkg::OP_ADD, 300, 100, 1);
      send_request(pcfe_pkg::OP_QUERY, 200, 100, 0);
      send_request(pcfe_pkg::OP_ADD, 200, 101, 0);
      send_request(pcfe_pkg::OP_QUERY, 200, 100, 1);
      send_request(pcfe_pkg::OP_QUERY, 200, 4095, 1);
      drain();

      // Random part: the near limit changes between phases, extremes included.
      limits[0] = 16'd0;
      limits[1] = 16'hFFFF;
      limits[2] = 16'($urandom_range(1, 400));
      limits[3] = 16'($urandom_range(0, 65535));
      limits[4] = 16'($urandom_range(1, 2000));
      limits[5] = 16'd1;
      for (int ph = 0; ph < 6; ph++) begin
         write_near_limit(limits[ph]);
         sender_idle_pct = ph < 2 ? 29 : (ph < 4 ? 66 : 0);
         while (items_sent < 16 + (ph + 1) * 285) begin
            // Some bursts run back to back even in the idling phases.
            if (sender_idle_pct != 0 && $urandom_range(0, 3) == 0) begin
               int keep;
               keep = sender_idle_pct;
               sender_idle_pct = 0;
               charge_burst();
               sender_idle_pct = keep;
            end else begin
               charge_burst();
            end
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (!sb.failed && sb.pending_results.size() == 0)
         $display("** point_charge_field_engine_unit: PASSED **");
      else
         $display("** point_charge_field_engine_unit: FAILED **");
      $finish;
   end
endmodule
